// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the top level of the nearest point table search unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Implication or plain property, checked on every rising clock edge.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// ===== hdl/npts_pkg.sv =====
// ---------------------------------------------------------------------------
// npts_pkg
// Constants, codes and types of the nearest point table search unit.
// ---------------------------------------------------------------------------
package npts_pkg;

   // Table geometry
   localparam int MAX_POINTS   = 1024;
   localparam int MAX_JOINTS   = 6;
   localparam int INPUT_JOINTS = 6;
   localparam int ADDR_W       = $clog2(MAX_POINTS);
   localparam int CNT_W        = $clog2(MAX_POINTS + 1);

   // Field widths
   localparam int COORD_W   = 16;
   localparam int LINK_W    = 11;
   localparam int INDEX_W   = 10;
   localparam int DIST_W    = 35;
   localparam int SQ_W      = 32;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int JOINT_W   = 3;
   localparam int COORDS_W  = MAX_JOINTS * COORD_W;
   localparam int ROW_W     = COORDS_W + LINK_W;
   localparam int PAIR_CNT  = (MAX_JOINTS + 1) / 2;

   // Stream widths
   localparam int REQ_FIELDS_W = INPUT_JOINTS * COORD_W + LINK_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = INDEX_W + LINK_W + DIST_W + INPUT_JOINTS * COORD_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Configuration reset value
   localparam logic [JOINT_W-1:0] ACTIVE_RESET = JOINT_W'(6);

   // Operation codes
   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_REPLY
   } state_type;

   // Tag that travels with each point through the distance pipeline
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [ADDR_W-1:0] idx;
   } scan_tag_type;

endpackage

// ===== hdl/npts_ram.sv =====
// ---------------------------------------------------------------------------
// npts_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module npts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/npts_dist.sv =====
// ---------------------------------------------------------------------------
// npts_dist
// Three-stage squared distance pipeline: per-joint squares, pair sums, total.
// ---------------------------------------------------------------------------
module npts_dist import npts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  scan_tag_type       tag_in,
   input  logic [ROW_W-1:0]   row,
   input  logic [COORDS_W-1:0] query,
   input  logic [JOINT_W-1:0] used,
   output scan_tag_type       tag_out,
   output logic [DIST_W-1:0]  dist_sq
);

   scan_tag_type      tag1_ff, tag2_ff, tag3_ff;
   logic [SQ_W-1:0]   sq_in  [PAIR_CNT*2];
   logic [SQ_W-1:0]   sq_ff  [PAIR_CNT*2];
   logic [SQ_W:0]     pair_in [PAIR_CNT];
   logic [SQ_W:0]     pair_ff [PAIR_CNT];
   logic [DIST_W-1:0] sum_in;
   logic [DIST_W-1:0] sum_ff;

   // Square the difference of each active joint, zero the rest
   always_comb begin
      logic signed [COORD_W:0]     diff;
      logic signed [2*COORD_W+1:0] prod;
      for (int j = 0; j < PAIR_CNT * 2; j++) begin
         sq_in[j] = '0;
         if (j < MAX_JOINTS) begin
            diff = $signed({row[j*COORD_W + COORD_W - 1], row[j*COORD_W +: COORD_W]})
                 - $signed({query[j*COORD_W + COORD_W - 1], query[j*COORD_W +: COORD_W]});
            prod = diff * diff;
            if (JOINT_W'(j) < used) begin
               sq_in[j] = prod[SQ_W-1:0];
            end
         end
      end
   end

   // Add squares in pairs
   always_comb begin
      for (int p = 0; p < PAIR_CNT; p++) begin
         pair_in[p] = {1'b0, sq_ff[2*p]} + {1'b0, sq_ff[2*p+1]};
      end
   end

   // Add the pair sums
   always_comb begin
      sum_in = '0;
      for (int p = 0; p < PAIR_CNT; p++) begin
         sum_in = sum_in + DIST_W'(pair_ff[p]);
      end
   end

   // Advance tags
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   // Advance data
   always_ff @(posedge clock) begin
      sq_ff   <= sq_in;
      pair_ff <= pair_in;
      sum_ff  <= sum_in;
   end

   assign tag_out = tag3_ff;
   assign dist_sq = sum_ff;

endmodule

// ===== hdl/nearest_point_table_search_unit.sv =====
// ---------------------------------------------------------------------------
// nearest_point_table_search_unit
// Table of joint-space points with append, clear and nearest point query.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one item per transfer; tuser carries the operation (add,
//   query, clear), tdata the six coordinates and the parent link. Every item
//   yields exactly one transfer on the rsp channel, in order.
//   csr channel: writes active_joints (always ready); write it only while the
//   unit is idle.
// Operation:
//   One item is in work at a time. After acceptance, an add writes the point
//   and reads it back, and a query scans the stored points; clear, query on
//   an empty table, add to a full table and the unused op go straight to the
//   result register. The next item can be accepted in the cycle after the
//   result register is loaded. The query time is set by the single RAM read
//   port, which feeds one stored point per cycle into a three-stage squared
//   distance pipeline; a final read fetches the winning entry.
//   The result sits in an output register, so a stalled receiver holds only
//   the finished result; the unit waits for the register to drain before it
//   writes the next one.
// Reset:
//   Clears the point count, sets active_joints to 6 and drops any pending
//   result. The table memory is not cleared; only entries below the count
//   are ever read.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_point_table_search_unit import npts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: coord_0 .. coord_5 (16 b each), parent_link (11 b), zero pad
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: op (2 b)
   input  logic [OP_W-1:0]       req_tuser,
   // rsp_tdata: best_index (10 b), best_parent (11 b), best_dist_sq (35 b),
   //            near_0 .. near_5 (16 b each)
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: status (2 b)
   output logic [STATUS_W-1:0]   rsp_tuser,
   // configuration: active_joints
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [JOINT_W-1:0]    csr_data
);

   state_type             state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [ROW_W-1:0]      item_ff, item_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     scan_addr_ff, scan_addr_in;
   logic [ADDR_W-1:0]     best_idx_ff, best_idx_in;
   logic [DIST_W-1:0]     best_dist_ff, best_dist_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  zero_ff, zero_in;
   logic [JOINT_W-1:0]    active_ff, active_in;
   scan_tag_type          tag_ff, tag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   rsp_user_ff, rsp_user_in;

   logic                  ram_wr_en;
   logic [ROW_W-1:0]      ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [ROW_W-1:0]      ram_rd_data;
   logic [JOINT_W-1:0]    used;
   scan_tag_type          dist_tag;
   logic [DIST_W-1:0]     dist_val;
   logic                  rsp_free;

   // Point table: coordinates in the low bits, parent link on top
   npts_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Distance pipeline
   npts_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (tag_ff),
      .row     (ram_rd_data),
      .query   (item_ff[COORDS_W-1:0]),
      .used    (used),
      .tag_out (dist_tag),
      .dist_sq (dist_val)
   );

   // Saturate the joint count
   assign used = (active_ff > JOINT_W'(MAX_JOINTS)) ? JOINT_W'(MAX_JOINTS) : active_ff;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   // Sequencer: next state and datapath control
   always_comb begin
      logic [COORDS_W-1:0] in_coords;
      logic [LINK_W-1:0]   in_link;
      state_in     = state_ff;
      op_in        = op_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      scan_addr_in = scan_addr_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      status_in    = status_ff;
      zero_in      = zero_ff;
      active_in    = active_ff;
      tag_in       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = scan_addr_ff;
      in_coords    = item_ff[COORDS_W-1:0];
      in_link      = (count_ff == '0) ? '0 : item_ff[ROW_W-1 -: LINK_W];
      ram_wr_data  = {in_link, in_coords};

      // Take a register write
      if (csr_valid) begin
         active_in = csr_data;
      end

      // Keep the first point with the least distance
      if (dist_tag.valid && (dist_tag.idx == '0 || dist_val < best_dist_ff)) begin
         best_dist_in = dist_val;
         best_idx_in  = dist_tag.idx;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               item_in  = req_tdata[ROW_W-1:0];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = STATUS_OK;
            zero_in   = 1'b1;
            state_in  = ST_REPLY;
            case (op_ff)
               OP_ADD: begin
                  if (count_ff >= CNT_W'(MAX_POINTS)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     ram_wr_en    = 1'b1;
                     best_idx_in  = count_ff[ADDR_W-1:0];
                     best_dist_in = '0;
                     count_in     = count_ff + 1'b1;
                     zero_in      = 1'b0;
                     state_in     = ST_FETCH;
                  end
               end
               OP_QUERY: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     scan_addr_in = '0;
                     zero_in      = 1'b0;
                     state_in     = ST_SCAN;
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            // Issue one stored point per cycle
            ram_rd_en    = 1'b1;
            ram_rd_addr  = scan_addr_ff;
            tag_in.valid = 1'b1;
            tag_in.idx   = scan_addr_ff;
            tag_in.last  = (CNT_W'(scan_addr_ff) + 1'b1 == count_ff);
            scan_addr_in = scan_addr_ff + 1'b1;
            if (tag_in.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (dist_tag.valid && dist_tag.last) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            // Read back the reported entry
            ram_rd_en   = 1'b1;
            ram_rd_addr = best_idx_ff;
            state_in    = ST_REPLY;
         end
         ST_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = '0;
               if (!zero_ff) begin
                  rsp_data_in[0 +: INDEX_W]      = INDEX_W'(best_idx_ff);
                  rsp_data_in[INDEX_W +: LINK_W] = ram_rd_data[ROW_W-1 -: LINK_W];
                  rsp_data_in[INDEX_W + LINK_W +: DIST_W] = best_dist_ff;
                  for (int j = 0; j < INPUT_JOINTS; j++) begin
                     if (j < MAX_JOINTS) begin
                        rsp_data_in[INDEX_W + LINK_W + DIST_W + j*COORD_W +: COORD_W] =
                           ram_rd_data[j*COORD_W +: COORD_W];
                     end
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         active_ff    <= ACTIVE_RESET;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      item_ff      <= item_in;
      scan_addr_ff <= scan_addr_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      status_ff    <= status_in;
      zero_ff      <= zero_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Checks
   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(MAX_POINTS), "point count overflow")
   `ASSERT_NEVER(a_write_full, clock, reset, ram_wr_en && count_ff >= CNT_W'(MAX_POINTS), "write to full table")
   `ASSERT_PROP(a_dist_in_scan, clock, reset, dist_tag.valid |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN), "distance result outside scan")
   `ASSERT_PROP(a_last_fetch, clock, reset, (dist_tag.valid && dist_tag.last) |=> state_ff == ST_FETCH, "scan end not followed by fetch")

endmodule

// ===== verif/tb_nearest_point_table_search_unit.sv =====
// ---------------------------------------------------------------------------
// tb_nearest_point_table_search_unit
// Self-checking bench for the nearest point table search unit: a local table
// tracks every add, query and clear, predicts each response in order, and
// compares it field by field with the rsp stream under random backpressure.
// ---------------------------------------------------------------------------
module tb_nearest_point_table_search_unit import npts_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_PCT    = 27;
   localparam int STALL_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 580;

   // op code that the unit ignores
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef logic [MAX_JOINTS-1:0][COORD_W-1:0] point_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [LINK_W-1:0]   parent;
      logic [DIST_W-1:0]   dist_sq;
      point_type           near;
   } reply_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [JOINT_W-1:0]    csr_data;

   // local copy of the table and of active_joints
   point_type         point_coords [MAX_POINTS];
   logic [LINK_W-1:0] point_links  [MAX_POINTS];
   int                point_total;
   int                joints_cfg;

   reply_type table_replies_due [$];

   bit quiet;
   int fail_count;
   int items_sent;
   int queries_sent;
   int replies_checked;
   int cfg_writes;
   int full_hits;
   int stall_cycles;

   nearest_point_table_search_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // squared distance from a stored entry over the active joints
   function automatic longint entry_dist_sq(int entry, point_type q);
      longint sum;
      longint d;
      int     used;
      sum  = 0;
      used = (joints_cfg > MAX_JOINTS) ? MAX_JOINTS : joints_cfg;
      for (int j = 0; j < used; j++) begin
         d   = longint'($signed(point_coords[entry][j])) - longint'($signed(q[j]));
         sum = sum + d * d;
      end
      return sum;
   endfunction

   // apply one item to the local table and return the response it causes
   function automatic reply_type compute_table_reply(logic [OP_W-1:0] op, point_type c,
                                                     logic [LINK_W-1:0] link);
      reply_type r;
      int        best;
      longint    best_d;
      longint    d;
      r        = '0;
      r.status = STATUS_OK;
      case (op)
         OP_ADD: begin
            if (point_total >= MAX_POINTS) begin
               r.status = STATUS_FULL;
               full_hits++;
            end else begin
               point_coords[point_total] = c;
               // first entry is always a root
               point_links[point_total]  = (point_total == 0) ? '0 : link;
               r.index  = INDEX_W'(point_total);
               r.parent = point_links[point_total];
               r.near   = c;
               point_total++;
            end
         end
         OP_QUERY: begin
            if (point_total == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               best   = 0;
               best_d = entry_dist_sq(0, c);
               // strict compare keeps the earliest entry on ties
               for (int k = 1; k < point_total; k++) begin
                  d = entry_dist_sq(k, c);
                  if (d < best_d) begin
                     best_d = d;
                     best   = k;
                  end
               end
               r.index   = INDEX_W'(best);
               r.parent  = point_links[best];
               r.dist_sq = DIST_W'(best_d);
               r.near    = point_coords[best];
            end
         end
         OP_CLEAR: begin
            point_total = 0;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // coordinate biased toward the extremes and small magnitudes
   function automatic logic [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2, 3: return COORD_W'($urandom_range(0, 511)) - 16'd256;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic point_type any_point();
      point_type p;
      for (int j = 0; j < MAX_JOINTS; j++) p[j] = random_coord();
      return p;
   endfunction

   // stored entry moved by a small offset on each joint
   function automatic point_type point_near_entry(int entry);
      point_type p;
      for (int j = 0; j < MAX_JOINTS; j++)
         p[j] = point_coords[entry][j] + COORD_W'($urandom_range(0, 63)) - 16'd32;
      return p;
   endfunction

   // drive one item and hold it until the transfer
   task automatic send_item(input logic [OP_W-1:0] op, input point_type c,
                            input logic [LINK_W-1:0] link);
      int        gap;
      reply_type due;
      gap = 0;
      if (!quiet) begin
         while ($urandom_range(0, 99) < IDLE_PCT) gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({link, c});
      do @(posedge clock); while (!req_tready);
      due = compute_table_reply(op, c, link);
      table_replies_due.insert(table_replies_due.size(), due);
      items_sent++;
      if (op == OP_QUERY) queries_sent++;
   endtask

   // drop valid and wait for every response plus the unit's wind-down
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (table_replies_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_active_joints(input int value);
      drain_replies();
      csr_valid <= 1'b1;
      csr_data  <= JOINT_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      joints_cfg = value;
      cfg_writes++;
   endtask

   // empty table, coordinate extremes, ties, clear and the unused op
   task automatic test_directed_cases();
      point_type hi;
      point_type lo;
      point_type mix;
      hi  = {MAX_JOINTS{16'h7fff}};
      lo  = {MAX_JOINTS{16'h8000}};
      mix = {16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h8000, 16'h7fff};
      send_item(OP_QUERY, hi, 11'd0);
      send_item(OP_UNUSED, hi, 11'd1024);
      send_item(OP_CLEAR, lo, 11'd0);
      send_item(OP_ADD, hi, 11'd1024);
      send_item(OP_QUERY, lo, 11'd0);
      send_item(OP_ADD, lo, 11'd1024);
      send_item(OP_ADD, mix, 11'd1023);
      send_item(OP_ADD, hi, 11'd1);
      send_item(OP_QUERY, hi, 11'd0);
      send_item(OP_QUERY, {MAX_JOINTS{16'h7000}}, 11'd0);
      send_item(OP_QUERY, mix, 11'd0);
      send_item(OP_QUERY, '0, 11'd0);
      send_item(OP_UNUSED, mix, 11'd1023);
      send_item(OP_CLEAR, hi, 11'd1024);
      send_item(OP_QUERY, mix, 11'd0);
      send_item(OP_ADD, mix, 11'd5);
      send_item(OP_QUERY, mix, 11'd0);
   endtask

   // several joint counts, including zero and the saturating value
   task automatic test_joint_counts();
      int        settings [4];
      point_type p;
      settings = '{0, 1, 7, 6};
      foreach (settings[s]) begin
         write_active_joints(settings[s]);
         send_item(OP_CLEAR, any_point(), 11'd0);
         repeat (3) send_item(OP_ADD, any_point(), LINK_W'($urandom_range(0, 1024)));
         p = point_near_entry(2);
         send_item(OP_QUERY, p, 11'd0);
         send_item(OP_QUERY, any_point(), 11'd0);
      end
   endtask

   // fill the table, overflow it, scan it whole, then empty it
   task automatic test_full_table();
      write_active_joints(6);
      send_item(OP_CLEAR, '0, 11'd0);
      repeat (MAX_POINTS) send_item(OP_ADD, any_point(), LINK_W'($urandom_range(0, 1024)));
      send_item(OP_ADD, any_point(), 11'd7);
      send_item(OP_QUERY, point_near_entry(MAX_POINTS - 1), 11'd0);
      send_item(OP_QUERY, any_point(), 11'd0);
      write_active_joints(2);
      send_item(OP_QUERY, point_near_entry($urandom_range(0, MAX_POINTS - 1)), 11'd0);
      send_item(OP_CLEAR, '0, 11'd0);
      send_item(OP_QUERY, any_point(), 11'd0);
   endtask

   // episodes of table building and queries with random joint counts
   task automatic test_random_traffic();
      int        episode;
      int        target;
      int        pick;
      int        n;
      point_type p;
      episode = 0;
      target  = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         quiet = (episode == 3 || episode == 4);
         if ($urandom_range(0, 2) == 0) write_active_joints($urandom_range(0, 7));
         // hold off once until everything in flight has come back
         if (episode == 6) drain_replies();
         if (point_total > 150 || $urandom_range(0, 3) == 0)
            send_item(OP_CLEAR, any_point(), LINK_W'($urandom_range(0, 1024)));
         n = $urandom_range(5, 40);
         repeat (n) begin
            pick = $urandom_range(0, 99);
            if (point_total == 0 && pick < 80) begin
               send_item(OP_ADD, any_point(), LINK_W'($urandom_range(0, 1024)));
            end else if (pick < 45) begin
               // some adds repeat a stored point to create ties
               if (point_total > 0 && $urandom_range(0, 7) == 0)
                  p = point_coords[$urandom_range(0, point_total - 1)];
               else
                  p = any_point();
               send_item(OP_ADD, p, LINK_W'($urandom_range(0, $urandom_range(0, 1) ?
                                                             point_total : 1024)));
            end else if (pick < 92) begin
               if (point_total > 0 && pick < 75)
                  p = point_near_entry($urandom_range(0, point_total - 1));
               else
                  p = any_point();
               send_item(OP_QUERY, p, LINK_W'($urandom));
            end else if (pick < 96) begin
               send_item(OP_CLEAR, any_point(), LINK_W'($urandom));
            end else begin
               send_item(OP_UNUSED, any_point(), LINK_W'($urandom));
            end
         end
         episode++;
      end
      quiet = 1'b0;
   endtask

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // check each response transfer and randomize the receiver's ready
   always @(posedge clock) begin : rsp_monitor
      reply_type want;
      reply_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[9:0], rsp_tdata[20:10], rsp_tdata[55:21],
                rsp_tdata[151:56]};
         if (table_replies_due.size() == 0) begin
            fail_count++;
            $display("%0t: response with none expected, expected nothing actual %h",
                     $time, got);
         end else begin
            want = table_replies_due.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("best_index", want.index, got.index);
            compare_field("best_parent", want.parent, got.parent);
            compare_field("best_dist_sq", want.dist_sq, got.dist_sq);
            for (int j = 0; j < MAX_JOINTS; j++)
               compare_field($sformatf("near_%0d", j), want.near[j], got.near[j]);
            replies_checked++;
         end
      end
      rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", stall_cycles);
         $display("tb_nearest_point_table_search_unit NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= OP_ADD;
      csr_valid   <= 1'b0;
      csr_data    <= '0;
      quiet       = 1'b0;
      fail_count  = 0;
      items_sent  = 0;
      queries_sent = 0;
      replies_checked = 0;
      cfg_writes  = 0;
      full_hits   = 0;
      point_total = 0;
      joints_cfg  = int'(ACTIVE_RESET);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_joint_counts();
      test_full_table();
      test_random_traffic();

      drain_replies();
      repeat (20) @(posedge clock);
      $display("Covered %0d items (%0d queries, %0d adds to a full table), %0d responses",
               items_sent, queries_sent, full_hits, replies_checked);
      $display("checked, over %0d active_joints writes from 0 to 7.", cfg_writes);
      if (fail_count == 0) begin
         $display("tb_nearest_point_table_search_unit OK");
      end else begin
         $display("tb_nearest_point_table_search_unit NOT OK");
      end
      $finish;
   end

endmodule

// ===== nearest_point_table_search_unit.f =====
+incdir+hdl
hdl/npts_pkg.sv
hdl/npts_ram.sv
hdl/npts_dist.sv
hdl/nearest_point_table_search_unit.sv
verif/tb_nearest_point_table_search_unit.sv
